// ===== rtl/skb_pkg.sv =====
// skb_pkg: shared types, codes and scancode tables for the key buffer
`timescale 1ns / 1ps

package skb_pkg;

  // request codes
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // action codes
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_KILL_ALL     = 3'd1;
  localparam logic [2:0] ACT_KILL_LEFT    = 3'd2;
  localparam logic [2:0] ACT_KILL_RIGHT   = 3'd3;
  localparam logic [2:0] ACT_FREEZE_LEFT  = 3'd4;
  localparam logic [2:0] ACT_FREEZE_RIGHT = 3'd5;
  localparam logic [2:0] ACT_LOAD_REGS    = 3'd6;

  // scancodes
  localparam logic [7:0] SC_LSHIFT  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT  = 8'h36;
  localparam logic [7:0] SC_RELEASE = 8'h80;
  localparam logic [7:0] SC_NONE    = 8'h00;

  // hotkey characters from the unshifted table
  localparam logic [7:0] KEY_ESC    = 8'd27;
  localparam logic [7:0] KEY_F1     = 8'd1;
  localparam logic [7:0] KEY_F2     = 8'd2;
  localparam logic [7:0] KEY_F3     = 8'd3;
  localparam logic [7:0] KEY_F4     = 8'd4;
  localparam logic [7:0] KEY_EQUALS = 8'h3D;

  // command passed from front to back
  typedef struct packed {
    logic [2:0] action;
    logic       wr_en;
    logic       rd_en;
    logic [7:0] wdata;
  } cmd_t;

  // unshifted set-1 table, zero past the end
  function automatic logic [7:0] plain_char(input logic [7:0] sc);
    logic [7:0] c;
    case (sc)
      8'd1:  c = 8'd27;
      8'd2:  c = 8'h31;
      8'd3:  c = 8'h32;
      8'd4:  c = 8'h33;
      8'd5:  c = 8'h34;
      8'd6:  c = 8'h35;
      8'd7:  c = 8'h36;
      8'd8:  c = 8'h37;
      8'd9:  c = 8'h38;
      8'd10: c = 8'h39;
      8'd11: c = 8'h30;
      8'd12: c = 8'h2D;
      8'd13: c = 8'h3D;
      8'd14: c = 8'h08;
      8'd15: c = 8'h09;
      8'd16: c = 8'h71;
      8'd17: c = 8'h77;
      8'd18: c = 8'h65;
      8'd19: c = 8'h72;
      8'd20: c = 8'h74;
      8'd21: c = 8'h79;
      8'd22: c = 8'h75;
      8'd23: c = 8'h69;
      8'd24: c = 8'h6F;
      8'd25: c = 8'h70;
      8'd26: c = 8'h5B;
      8'd27: c = 8'h5D;
      8'd28: c = 8'h0A;
      8'd30: c = 8'h61;
      8'd31: c = 8'h73;
      8'd32: c = 8'h64;
      8'd33: c = 8'h66;
      8'd34: c = 8'h67;
      8'd35: c = 8'h68;
      8'd36: c = 8'h6A;
      8'd37: c = 8'h6B;
      8'd38: c = 8'h6C;
      8'd39: c = 8'h3B;
      8'd40: c = 8'h27;
      8'd41: c = 8'h60;
      8'd43: c = 8'h5C;
      8'd44: c = 8'h7A;
      8'd45: c = 8'h78;
      8'd46: c = 8'h63;
      8'd47: c = 8'h76;
      8'd48: c = 8'h62;
      8'd49: c = 8'h6E;
      8'd50: c = 8'h6D;
      8'd51: c = 8'h2C;
      8'd52: c = 8'h2E;
      8'd53: c = 8'h2F;
      8'd55: c = 8'h2A;
      8'd57: c = 8'h20;
      8'd59: c = 8'd1;
      8'd60: c = 8'd2;
      8'd61: c = 8'd3;
      8'd62: c = 8'd4;
      8'd74: c = 8'h2D;
      8'd78: c = 8'h2B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // shifted set-1 table, zero past the end
  function automatic logic [7:0] shift_char(input logic [7:0] sc);
    logic [7:0] c;
    case (sc)
      8'd1:  c = 8'd27;
      8'd2:  c = 8'h21;
      8'd3:  c = 8'h40;
      8'd4:  c = 8'h23;
      8'd5:  c = 8'h24;
      8'd6:  c = 8'h25;
      8'd7:  c = 8'h5E;
      8'd8:  c = 8'h26;
      8'd9:  c = 8'h2A;
      8'd10: c = 8'h28;
      8'd11: c = 8'h29;
      8'd12: c = 8'h5F;
      8'd13: c = 8'h2B;
      8'd14: c = 8'h08;
      8'd15: c = 8'h09;
      8'd16: c = 8'h51;
      8'd17: c = 8'h57;
      8'd18: c = 8'h45;
      8'd19: c = 8'h52;
      8'd20: c = 8'h54;
      8'd21: c = 8'h59;
      8'd22: c = 8'h55;
      8'd23: c = 8'h49;
      8'd24: c = 8'h4F;
      8'd25: c = 8'h50;
      8'd26: c = 8'h7B;
      8'd27: c = 8'h7D;
      8'd28: c = 8'h0A;
      8'd30: c = 8'h41;
      8'd31: c = 8'h53;
      8'd32: c = 8'h44;
      8'd33: c = 8'h46;
      8'd34: c = 8'h47;
      8'd35: c = 8'h48;
      8'd36: c = 8'h4A;
      8'd37: c = 8'h4B;
      8'd38: c = 8'h4C;
      8'd39: c = 8'h3A;
      8'd40: c = 8'h22;
      8'd41: c = 8'h7E;
      8'd43: c = 8'h7C;
      8'd44: c = 8'h5A;
      8'd45: c = 8'h58;
      8'd46: c = 8'h43;
      8'd47: c = 8'h56;
      8'd48: c = 8'h42;
      8'd49: c = 8'h4E;
      8'd50: c = 8'h4D;
      8'd51: c = 8'h3C;
      8'd52: c = 8'h3E;
      8'd53: c = 8'h3F;
      8'd55: c = 8'h2A;
      8'd57: c = 8'h20;
      8'd74: c = 8'h2D;
      8'd78: c = 8'h2B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/scancode_to_ascii_key_buffer.sv =====
// scancode_to_ascii_key_buffer: set-1 scancode decoder with a character buffer
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   in      | input     | in_valid, in_stall, in_req_type, in_scancode
//   out     | output    | out_valid, out_stall, out_action, out_read_char,
//           |           | out_read_valid
//
// one transfer per cycle is sustained while in_stall is low; a result is set
// by the queue slot write and then by the registered memory read
// a two-entry queue parts the front (pointers, shift, hotkeys) from the back
// (character memory, output register), so each side stalls on its own
// reset clears pointers, shift flag, queue and output valid; the character
// memory is not cleared and needs no sweep
`timescale 1ns / 1ps

module scancode_to_ascii_key_buffer #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_action,
  output logic [7:0] out_read_char,
  output logic       out_read_valid
);

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CMD_W = $bits(skb_pkg::cmd_t);
  localparam int Q_W   = CMD_W + PTR_W;

  logic             push, pop, full, not_empty;
  skb_pkg::cmd_t    f_cmd, b_cmd;
  logic [PTR_W-1:0] f_addr, b_addr;
  logic [Q_W-1:0]   q_out;

  // front: classify and update pointers
  skb_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PTR_W        (PTR_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_scancode (in_scancode),
    .q_full      (full),
    .q_push      (push),
    .q_cmd       (f_cmd),
    .q_addr      (f_addr)
  );

  // command queue
  skb_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_addr, f_cmd}),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (q_out)
  );

  assign b_cmd  = q_out[CMD_W-1:0];
  assign b_addr = q_out[Q_W-1:CMD_W];

  // back: memory and results
  skb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PTR_W        (PTR_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (not_empty),
    .q_cmd          (b_cmd),
    .q_addr         (b_addr),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_read_char  (out_read_char),
    .out_read_valid (out_read_valid)
  );

endmodule

// ===== rtl/skb_front.sv =====
// skb_front: accepts requests, decodes hotkeys and keeps the buffer pointers
`timescale 1ns / 1ps

module skb_front #(
  parameter int BUFFER_DEPTH = 256,
  parameter int PTR_W        = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [7:0]        in_scancode,
  input  logic              q_full,
  output logic              q_push,
  output skb_pkg::cmd_t     q_cmd,
  output logic [PTR_W-1:0]  q_addr
);

  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(BUFFER_DEPTH - 1);

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic             shift_r, shift_nxt;
  logic [PTR_W-1:0] wp_base;
  logic [7:0]       key;
  logic [2:0]       hot_action;
  logic             hot_stop;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign key      = skb_pkg::plain_char(in_scancode);

  // hotkey decode, always from the unshifted table
  always_comb begin
    hot_stop   = 1'b1;
    hot_action = skb_pkg::ACT_NONE;
    case (key)
      skb_pkg::KEY_ESC: hot_action = skb_pkg::ACT_KILL_ALL;
      skb_pkg::KEY_F3:  hot_action = skb_pkg::ACT_KILL_LEFT;
      skb_pkg::KEY_F4:  hot_action = skb_pkg::ACT_KILL_RIGHT;
      skb_pkg::KEY_F1:  hot_action = skb_pkg::ACT_FREEZE_LEFT;
      skb_pkg::KEY_F2:  hot_action = skb_pkg::ACT_FREEZE_RIGHT;
      skb_pkg::KEY_EQUALS: begin
        hot_stop   = 1'b0;
        hot_action = skb_pkg::ACT_LOAD_REGS;
      end
      default: hot_stop = 1'b0;
    endcase
  end

  // pointer, shift and command generation
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    shift_nxt = shift_r;
    wp_base   = wp_r;
    q_cmd     = '0;
    q_addr    = '0;
    if (accept) begin
      if (in_req_type == skb_pkg::REQ_READ) begin
        if (rp_r < wp_r) begin
          q_cmd.rd_en = 1'b1;
          q_addr      = rp_r;
          rp_nxt      = PTR_W'(rp_r + 1'b1);
        end
      end else begin
        q_cmd.action = hot_action;
        if (!hot_stop) begin
          // wrap drops whatever is unread
          if (wp_r == LAST_POS) begin
            wp_base = '0;
            rp_nxt  = '0;
          end
          wp_nxt = wp_base;
          if (in_scancode == skb_pkg::SC_LSHIFT || in_scancode == skb_pkg::SC_RSHIFT) begin
            shift_nxt = 1'b1;
          end
          if (in_scancode == (skb_pkg::SC_LSHIFT | skb_pkg::SC_RELEASE) ||
              in_scancode == (skb_pkg::SC_RSHIFT | skb_pkg::SC_RELEASE)) begin
            shift_nxt = 1'b0;
          end
          if (in_scancode < skb_pkg::SC_RELEASE && in_scancode != skb_pkg::SC_NONE) begin
            q_cmd.wr_en = 1'b1;
            q_cmd.wdata = shift_nxt ? skb_pkg::shift_char(in_scancode) : key;
            q_addr      = wp_base;
            wp_nxt      = PTR_W'(wp_base + 1'b1);
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      shift_r <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// ===== rtl/skb_queue.sv =====
// skb_queue: two-entry command queue between front and back
`timescale 1ns / 1ps

module skb_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/skb_back.sv =====
// skb_back: character memory and output register
`timescale 1ns / 1ps

module skb_back #(
  parameter int BUFFER_DEPTH = 256,
  parameter int PTR_W        = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  skb_pkg::cmd_t     q_cmd,
  input  logic [PTR_W-1:0]  q_addr,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_action,
  output logic [7:0]        out_read_char,
  output logic              out_read_valid
);

  logic [7:0] mem_r [BUFFER_DEPTH];
  logic [7:0] rd_data_r;
  logic       out_valid_r;
  logic [2:0] action_r;
  logic       rd_sel_r;

  // take a command when the output slot is free or being emptied
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // memory access and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      action_r <= q_cmd.action;
      rd_sel_r <= q_cmd.rd_en;
      if (q_cmd.wr_en) begin
        mem_r[q_addr] <= q_cmd.wdata;
      end
      if (q_cmd.rd_en) begin
        rd_data_r <= mem_r[q_addr];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = action_r;
  assign out_read_valid = rd_sel_r;
  assign out_read_char  = rd_sel_r ? rd_data_r : 8'h00;

endmodule

// ===== rtl/skb_checker.sv =====
// skb_checker: port-level assertions for the key buffer, bound to the top level
`timescale 1ns / 1ps

module skb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_action,
  input logic [7:0] out_read_char,
  input logic       out_read_valid
);

  // stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_read_char) && $stable(out_read_valid))
    else $error("stalled result changed");

  // no character without a successful read
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_char == 8'h00)
    else $error("character shown without a read");

  // a read never carries an action
  a_read_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_action == skb_pkg::ACT_NONE)
    else $error("action on a read result");

  // action code in range
  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_action <= skb_pkg::ACT_LOAD_REGS)
    else $error("action code out of range");

endmodule

bind scancode_to_ascii_key_buffer skb_checker u_skb_checker (.*);

// ===== test/scancode_to_ascii_key_buffer_test.sv =====
// scancode_to_ascii_key_buffer_test: random and directed checks of the scancode key buffer
`timescale 1ns / 1ps

module scancode_to_ascii_key_buffer_test;

  localparam int BUF_DEPTH    = 256;
  localparam int BUF_AW       = $clog2(BUF_DEPTH);
  localparam int RANDOM_ITEMS = 1000;
  localparam int PAUSE_EVERY  = 300;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] read_char;
    logic       read_valid;
  } key_result_t;

  typedef struct {
    logic       req_type;
    logic [7:0] scancode;
    bit         drain_first;
  } key_req_t;

  typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_req_type = skb_pkg::REQ_SCAN;
  logic [7:0] in_scancode = skb_pkg::SC_NONE;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_action;
  logic [7:0] out_read_char;
  logic       out_read_valid;

  // low part of the set-1 tables, codes 0 to 57
  logic [7:0] plain_low [0:57] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };
  logic [7:0] shift_low [0:57] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // shadow copy of the buffer state
  logic [7:0] key_mem [BUF_DEPTH];
  int         wr_ptr = 0;
  int         rd_ptr = 0;
  logic       shift_on = 1'b0;

  key_req_t    pending_reqs [$];
  key_result_t results_due [$];
  key_result_t due;
  key_req_t    cur_req;
  bit          drain_next = 1'b0;
  int          made = 0;
  int          errors = 0;

  logic        in_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        long_stall = 1'b0;

  scancode_to_ascii_key_buffer #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_scancode   (in_scancode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_read_char (out_read_char),
    .out_read_valid(out_read_valid)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("scancode_to_ascii_key_buffer_test failed");
    $finish;
  end

  // character of a code, zero past the end of the table
  function automatic logic [7:0] key_char(input logic shifted, input logic [7:0] sc);
    logic [7:0] c;
    c = 8'h00;
    if (sc < 8'd58) c = shifted ? shift_low[6'(sc)] : plain_low[6'(sc)];
    else if (sc == 8'd74) c = 8'h2D;
    else if (sc == 8'd78) c = 8'h2B;
    else if (!shifted && sc >= 8'd59 && sc <= 8'd62) c = sc - 8'd58;  // F1 to F4
    return c;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic key_result_t decode_request(input logic req, input logic [7:0] sc);
    key_result_t r;
    logic [7:0]  key;
    bit          halt;
    r = '0;
    if (req == skb_pkg::REQ_READ) begin
      if (rd_ptr < wr_ptr) begin
        r.read_char  = key_mem[BUF_AW'(rd_ptr)];
        r.read_valid = 1'b1;
        rd_ptr++;
      end
    end else begin
      // hotkeys always come from the unshifted table
      key  = key_char(1'b0, sc);
      halt = 1'b1;
      case (key)
        skb_pkg::KEY_ESC: r.action = skb_pkg::ACT_KILL_ALL;
        skb_pkg::KEY_F3:  r.action = skb_pkg::ACT_KILL_LEFT;
        skb_pkg::KEY_F4:  r.action = skb_pkg::ACT_KILL_RIGHT;
        skb_pkg::KEY_F1:  r.action = skb_pkg::ACT_FREEZE_LEFT;
        skb_pkg::KEY_F2:  r.action = skb_pkg::ACT_FREEZE_RIGHT;
        default: begin
          halt = 1'b0;
          if (key == skb_pkg::KEY_EQUALS) r.action = skb_pkg::ACT_LOAD_REGS;
        end
      endcase
      if (!halt) begin
        if (wr_ptr >= BUF_DEPTH - 1) begin
          wr_ptr = 0;
          rd_ptr = 0;
        end
        if (sc == skb_pkg::SC_LSHIFT || sc == skb_pkg::SC_RSHIFT) shift_on = 1'b1;
        if (sc == (skb_pkg::SC_LSHIFT | skb_pkg::SC_RELEASE) ||
            sc == (skb_pkg::SC_RSHIFT | skb_pkg::SC_RELEASE)) shift_on = 1'b0;
        if (sc < skb_pkg::SC_RELEASE && sc != skb_pkg::SC_NONE) begin
          key_mem[BUF_AW'(wr_ptr)] = key_char(shift_on, sc);
          wr_ptr++;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic queue_request(input logic req, input logic [7:0] sc);
    key_req_t r;
    r.req_type    = req;
    r.scancode    = sc;
    r.drain_first = drain_next;
    drain_next    = 1'b0;
    pending_reqs.push_back(r);
    made++;
  endtask

  // sender: bursts of transfers with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && results_due.size() != 0)) begin
        cur_req = pending_reqs.pop_front();
        in_req_type <= cur_req.req_type;
        in_scancode <= cur_req.scancode;
        in_valid    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:    out_stall <= 1'b0;
      STALL_SCATTER: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (run_left == 0) begin
          run_left   = $urandom_range(1, 16);
          long_stall = !long_stall;
        end else begin
          run_left--;
        end
        out_stall <= long_stall;
      end
    endcase
  end

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result action=%0d char=%02h valid=%0d",
                                    out_action, out_read_char, out_read_valid));
        end else begin
          due = results_due.pop_front();
          if (out_action !== due.action)
            report_mismatch($sformatf("action %0d, expected %0d", out_action, due.action));
          if (out_read_char !== due.read_char)
            report_mismatch($sformatf("read_char %02h, expected %02h",
                                      out_read_char, due.read_char));
          if (out_read_valid !== due.read_valid)
            report_mismatch($sformatf("read_valid %0d, expected %0d",
                                      out_read_valid, due.read_valid));
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back(decode_request(in_req_type, in_scancode));
    end
  end

  initial begin
    int   n;
    int   k;
    int   next_pause;
    logic held;
    logic [7:0] sc;

    // directed: empty read, hotkeys, shift, zero characters, releases
    queue_request(skb_pkg::REQ_READ, 8'hFF);
    queue_request(skb_pkg::REQ_SCAN, skb_pkg::SC_NONE);
    queue_request(skb_pkg::REQ_SCAN, 8'h01);
    queue_request(skb_pkg::REQ_SCAN, 8'h3B);
    queue_request(skb_pkg::REQ_SCAN, 8'h3C);
    queue_request(skb_pkg::REQ_SCAN, 8'h3D);
    queue_request(skb_pkg::REQ_SCAN, 8'h3E);
    queue_request(skb_pkg::REQ_SCAN, 8'h0D);
    queue_request(skb_pkg::REQ_SCAN, 8'h1E);
    queue_request(skb_pkg::REQ_SCAN, skb_pkg::SC_LSHIFT);
    queue_request(skb_pkg::REQ_SCAN, 8'h1E);
    queue_request(skb_pkg::REQ_SCAN, 8'h3B);
    queue_request(skb_pkg::REQ_SCAN, 8'h35);
    queue_request(skb_pkg::REQ_SCAN, skb_pkg::SC_LSHIFT | skb_pkg::SC_RELEASE);
    queue_request(skb_pkg::REQ_SCAN, 8'h1D);
    queue_request(skb_pkg::REQ_SCAN, 8'h7F);
    queue_request(skb_pkg::REQ_SCAN, 8'h81);
    queue_request(skb_pkg::REQ_SCAN, 8'hFF);
    drain_next = 1'b1;
    for (k = 0; k < 8; k++) queue_request(skb_pkg::REQ_READ, skb_pkg::SC_NONE);

    // random: mostly typing runs with reads, some read bursts and noise
    made       = 0;
    next_pause = PAUSE_EVERY;
    while (made < RANDOM_ITEMS) begin
      if (made >= next_pause) begin
        drain_next = 1'b1;
        next_pause += PAUSE_EVERY;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          held = ($urandom_range(0, 2) == 0);
          if (held)
            queue_request(skb_pkg::REQ_SCAN,
                          $urandom_range(0, 1) ? skb_pkg::SC_LSHIFT : skb_pkg::SC_RSHIFT);
          n = $urandom_range(1, 14);
          for (k = 0; k < n; k++) begin
            sc = 8'($urandom_range(1, 89));
            queue_request(skb_pkg::REQ_SCAN, sc);
            if ($urandom_range(0, 3) == 0)
              queue_request(skb_pkg::REQ_SCAN, sc | skb_pkg::SC_RELEASE);
          end
          if (held && $urandom_range(0, 3) != 0)
            queue_request(skb_pkg::REQ_SCAN,
                          ($urandom_range(0, 1) ? skb_pkg::SC_LSHIFT : skb_pkg::SC_RSHIFT) |
                          skb_pkg::SC_RELEASE);
          n = $urandom_range(0, 6);
          for (k = 0; k < n; k++)
            queue_request(skb_pkg::REQ_READ, 8'($urandom_range(0, 255)));
        end
        5, 6: begin
          n = $urandom_range(1, 24);
          for (k = 0; k < n; k++)
            queue_request(skb_pkg::REQ_READ, 8'($urandom_range(0, 255)));
        end
        default: queue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      endcase
    end

    // reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("scancode_to_ascii_key_buffer_test passed");
    end else begin
      $display("scancode_to_ascii_key_buffer_test failed");
    end
    $finish;
  end

endmodule
